>>> rtl/core/armt_pkg.sv
// ----------------------------------------------------------------------------
// armt_pkg
// Shared types, codes and widths of the address region match table.
// ----------------------------------------------------------------------------
package armt_pkg;

    // field widths
    localparam int ADDR_W   = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 6;

    // default table depth
    localparam int MAX_ENTRIES_DEF = 64;

    // register indexes
    localparam logic REG_MODULE_BASE = 1'b0;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd4;

    // search token passed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] target;
    } armt_tok_t;

    // region written into one cell
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } armt_wr_t;

endpackage

>>> rtl/core/address_region_match_table.sv
// ----------------------------------------------------------------------------
// address_region_match_table
// First-match table of address regions, searched by a chain of cells.
// ----------------------------------------------------------------------------
// Usage
//   s_* stream: one command per transfer (clear, load region, look up).
//   m_* stream: one result per clear, load or lookup; cmd 3 gives none.
//   APB port: module_base at address 0, added to relative starts on load.
// Result path
//   clear and load: result valid in the cycle after the input transfer.
//   lookup: the search token steps through the cell registers, one cell
//   per cycle, and the result register takes it as it leaves the last cell.
// Throughput
//   one item in flight; s_tready is high when the block is not searching
//   and the output register is empty or being taken in that cycle.
//   so one clear or load per cycle while results are taken; no new command while a lookup searches.
// Reset
//   empties the table (entry count zero) and sets module_base to zero.
// Stall
//   a result held on m_* keeps s_tready low until it is taken.
// ----------------------------------------------------------------------------
module address_region_match_table
    import armt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,   // region_start, region_size, target_address
    input  logic [2:0]    s_tuser,   // cmd[1:0], is_relative
    // output stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [135:0]  m_tdata,   // match_index, match_start, match_size, pad
    output logic [2:0]    m_tuser,   // status
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [IDX_W-1:0]    out_idx_reg, out_idx_next;
    logic [ADDR_W-1:0]   out_start_reg, out_start_next;
    logic [ADDR_W-1:0]   out_size_reg, out_size_next;
    logic [ADDR_W-1:0]   base_reg;

    logic [CMD_W-1:0]    in_cmd;
    logic                in_rel;
    logic [ADDR_W-1:0]   in_start;
    logic [ADDR_W-1:0]   in_size;
    logic [ADDR_W-1:0]   in_target;
    logic [ADDR_W-1:0]   abs_start;
    logic                in_ready;
    logic                in_xfer;
    logic                full;
    logic                load_we;

    armt_wr_t            wr;
    armt_tok_t           chain [0:MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_we;
    logic [MAX_ENTRIES-1:0] cell_in_use;

    // input unpacking
    assign in_cmd    = s_tuser[1:0];
    assign in_rel    = s_tuser[2];
    assign in_start  = s_tdata[63:0];
    assign in_size   = s_tdata[127:64];
    assign in_target = s_tdata[191:128];

    // handshake
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && in_ready;
    assign s_tready = in_ready;

    // load path
    assign full      = (count_reg >= CNT_W'(MAX_ENTRIES));
    assign abs_start = in_rel ? (in_start + base_reg) : in_start;
    assign load_we   = in_xfer && (in_cmd == CMD_LOAD) && !full;
    assign wr.start  = abs_start;
    assign wr.size   = in_size;

    // search token entering the chain
    always_comb
    begin
        chain[0]        = '0;
        chain[0].vld    = in_xfer && (in_cmd == CMD_LOOKUP);
        chain[0].target = in_target;
    end

    // row of cells
    for (genvar k = 0; k < MAX_ENTRIES; k++)
    begin : g_cell
        assign cell_we[k]     = load_we && (count_reg == CNT_W'(k));
        assign cell_in_use[k] = (CNT_W'(k) < count_reg);

        armt_cell #(
            .CELL_INDEX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .we      (cell_we[k]),
            .in_use  (cell_in_use[k]),
            .wr      (wr),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );
    end

    // next-state and result logic
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_start_next  = out_start_reg;
        out_size_next   = out_size_reg;

        if (in_xfer)
        begin
            unique case (in_cmd)
                CMD_CLEAR:
                begin
                    count_next      = '0;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_CLEARED;
                    out_idx_next    = '0;
                    out_start_next  = '0;
                    out_size_next   = '0;
                end
                CMD_LOAD:
                begin
                    out_valid_next = 1'b1;
                    if (full)
                    begin
                        out_status_next = ST_FULL;
                        out_idx_next    = '0;
                        out_start_next  = '0;
                        out_size_next   = '0;
                    end
                    else
                    begin
                        count_next      = count_reg + CNT_W'(1);
                        out_status_next = ST_LOADED;
                        out_idx_next    = IDX_W'(count_reg);
                        out_start_next  = abs_start;
                        out_size_next   = in_size;
                    end
                end
                CMD_LOOKUP:
                begin
                    state_next = S_SEARCH;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        // token leaving the last cell
        if ((state_reg == S_SEARCH) && chain[MAX_ENTRIES].vld)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            if (chain[MAX_ENTRIES].hit)
            begin
                out_status_next = ST_HIT;
                out_idx_next    = chain[MAX_ENTRIES].idx;
                out_start_next  = chain[MAX_ENTRIES].start;
                out_size_next   = chain[MAX_ENTRIES].size;
            end
            else
            begin
                out_status_next = ST_MISS;
                out_idx_next    = '0;
                out_start_next  = '0;
                out_size_next   = '0;
            end
        end
    end

    // state, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_CLEARED;
            out_idx_reg    <= '0;
            out_start_reg  <= '0;
            out_size_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_idx_reg    <= out_idx_next;
            out_start_reg  <= out_start_next;
            out_size_reg   <= out_size_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[3] == REG_MODULE_BASE))
        begin
            base_reg <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_MODULE_BASE) ? base_reg : '0;

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_size_reg, out_start_reg, out_idx_reg};

endmodule

>>> rtl/core/armt_cell.sv
// ----------------------------------------------------------------------------
// armt_cell
// One table entry; checks the passing search token against its region.
// ----------------------------------------------------------------------------
module armt_cell
    import armt_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      we,
    input  logic      in_use,
    input  armt_wr_t  wr,
    input  armt_tok_t tok_in,
    output armt_tok_t tok_out
);

    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] size_reg;
    logic              covers;
    armt_tok_t         tok_next;
    armt_tok_t         tok_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_reg <= wr.start;
            size_reg  <= wr.size;
        end
    end

    // inclusive range check, end sum never wraps
    assign covers = (tok_in.target >= start_reg) &&
                    ((tok_in.target - start_reg) <= size_reg);

    // first match claims the token
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.vld && !tok_in.hit && in_use && covers)
        begin
            tok_next.hit   = 1'b1;
            tok_next.idx   = IDX_W'(CELL_INDEX);
            tok_next.start = start_reg;
            tok_next.size  = size_reg;
        end
    end

    // token register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/armt_checker.sv
// ----------------------------------------------------------------------------
// armt_checker
// Port-level checks of the address region match table.
// ----------------------------------------------------------------------------
module armt_checker
    import armt_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [2:0]    s_tuser,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [135:0]  m_tdata,
    input logic [2:0]    m_tuser
);

    // status is always a defined code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= ST_MISS))
        else $error("undefined status code");

    // a held result blocks the input side
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    // stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // results without an entry carry zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tuser == ST_CLEARED) || (m_tuser == ST_FULL) ||
                      (m_tuser == ST_MISS))) |-> (m_tdata == '0))
        else $error("nonzero fields on result without entry");

    // a clear answers in the next cycle
    a_clear_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[1:0] == CMD_CLEAR)) |=>
        (m_tvalid && (m_tuser == ST_CLEARED)))
        else $error("clear transfer without cleared result");

endmodule

bind address_region_match_table armt_checker u_armt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/region_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_table_checker
// Watches the command, result and register channels of the region table,
// keeps a shadow copy of the table and checks each result transfer in order.
// ----------------------------------------------------------------------------
module region_table_checker
    import armt_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [191:0]  s_tdata,   // region_start, region_size, target_address
    input  logic [2:0]    s_tuser,   // cmd[1:0], is_relative
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [135:0]  m_tdata,   // match_index, match_start, match_size, pad
    input  logic [2:0]    m_tuser,   // status
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    input  logic          pready,
    output int            errors,
    output int            pending
);

    localparam logic [3:0] BASE_ADDR = {REG_MODULE_BASE, 3'b000};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    index;
        logic [ADDR_W-1:0]   start;
        logic [ADDR_W-1:0]   size;
    } region_reply_t;

    // shadow of the table and the base register
    logic [ADDR_W-1:0] base_shadow;
    logic [ADDR_W-1:0] start_shadow [MAX_ENTRIES];
    logic [ADDR_W-1:0] size_shadow  [MAX_ENTRIES];
    int                fill;
    region_reply_t     awaited_replies [$];

    // inclusive end, compared as a difference so it never wraps
    function automatic bit region_covers(logic [ADDR_W-1:0] start,
                                         logic [ADDR_W-1:0] size,
                                         logic [ADDR_W-1:0] addr);
        return (addr >= start) && ((addr - start) <= size);
    endfunction

    // apply one command to the shadow table; returns 0 when no result follows
    function automatic bit apply_region_op(logic [CMD_W-1:0] cmd, logic rel,
                                           logic [ADDR_W-1:0] rstart,
                                           logic [ADDR_W-1:0] rsize,
                                           logic [ADDR_W-1:0] target,
                                           output region_reply_t reply);
        logic [ADDR_W-1:0] abs_start;
        int                k;
        bit                found;
        reply = '0;
        found = 1'b0;
        case (cmd)
            CMD_CLEAR:
            begin
                fill = 0;
                reply.status = ST_CLEARED;
            end
            CMD_LOAD:
            begin
                if (fill >= MAX_ENTRIES)
                begin
                    reply.status = ST_FULL;
                end
                else
                begin
                    abs_start = rel ? rstart + base_shadow : rstart;
                    start_shadow[fill] = abs_start;
                    size_shadow[fill] = rsize;
                    reply.status = ST_LOADED;
                    reply.index = IDX_W'(fill);
                    reply.start = abs_start;
                    reply.size = rsize;
                    fill++;
                end
            end
            CMD_LOOKUP:
            begin
                reply.status = ST_MISS;
                for (k = 0; k < fill; k++)
                begin
                    if (!found && region_covers(start_shadow[k], size_shadow[k], target))
                    begin
                        found = 1'b1;
                        reply.status = ST_HIT;
                        reply.index = IDX_W'(k);
                        reply.start = start_shadow[k];
                        reply.size = size_shadow[k];
                    end
                end
            end
            default:
            begin
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // channel monitor: compare results first, then predict the new transfer
    always @(posedge clk or negedge rst_n)
    begin
        region_reply_t want;
        region_reply_t got;
        if (!rst_n)
        begin
            base_shadow = '0;
            fill = 0;
            errors = 0;
            awaited_replies.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.index = m_tdata[5:0];
                got.start = m_tdata[69:6];
                got.size = m_tdata[133:70];
                if (awaited_replies.size() == 0)
                begin
                    $error("unexpected result transfer, status %0d", got.status);
                    errors++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.index !== want.index)
                    begin
                        $error("match_index expected %0d actual %0d", want.index, got.index);
                        errors++;
                    end
                    if (got.start !== want.start)
                    begin
                        $error("match_start expected %h actual %h", want.start, got.start);
                        errors++;
                    end
                    if (got.size !== want.size)
                    begin
                        $error("match_size expected %h actual %h", want.size, got.size);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (apply_region_op(s_tuser[1:0], s_tuser[2], s_tdata[63:0],
                                    s_tdata[127:64], s_tdata[191:128], want))
                begin
                    awaited_replies.push_back(want);
                end
            end
            if (psel && penable && pwrite && pready && paddr == BASE_ADDR)
            begin
                base_shadow = pwdata;
            end
            pending = awaited_replies.size();
        end
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the address region match table: directed loads and lookups
// around region edges, then random clear/load/lookup runs with random gaps,
// result stalls and module base changes. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import armt_pkg::*;

    localparam int               TABLE_DEPTH = MAX_ENTRIES_DEF;
    localparam int               DRAIN_WAIT  = TABLE_DEPTH + 8;
    localparam int               ITEM_GOAL   = 1750;
    localparam logic [3:0]       BASE_ADDR   = {REG_MODULE_BASE, 3'b000};
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam logic [63:0]      ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [191:0]  s_tdata;   // region_start, region_size, target_address
    logic [2:0]    s_tuser;   // cmd[1:0], is_relative
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [135:0]  m_tdata;   // match_index, match_start, match_size, pad
    logic [2:0]    m_tuser;   // status
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [3:0]    paddr;
    logic [63:0]   pwdata;
    logic [63:0]   prdata;
    logic          pready;
    int            errors;
    int            pending;

    // stimulus-side view of the table, used only to aim lookups
    logic [63:0]   cur_base;
    logic [63:0]   loaded_start [$];
    logic [63:0]   loaded_size  [$];
    bit            calm;
    int            sent;
    int            stall_left;

    address_region_match_table #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    region_table_checker #(.MAX_ENTRIES(TABLE_DEPTH)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // hard stop in case the block hangs
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, a few long ones, none in a calm stretch
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // one command transfer, entered and left at a falling edge
    task automatic send_item(logic [CMD_W-1:0] cmd, logic rel, logic [63:0] rstart,
                             logic [63:0] rsize, logic [63:0] target);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {target, rsize, rstart};
        s_tuser <= {rel, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (cmd == CMD_CLEAR)
        begin
            loaded_start.delete();
            loaded_size.delete();
        end
        else if (cmd == CMD_LOAD && loaded_start.size() < TABLE_DEPTH)
        begin
            loaded_start.push_back(rel ? rstart + cur_base : rstart);
            loaded_size.push_back(rsize);
        end
        if (cmd != CMD_IGNORED)
            sent++;
    endtask

    // module base write, only once the block has drained
    task automatic write_base(logic [63:0] value);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= BASE_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_base = value;
    endtask

    // load a region clustered around the window, absolute or base-relative
    task automatic load_region(logic [63:0] window);
        logic [63:0] abs_start;
        logic [63:0] rsize;
        logic        rel;
        int          r;
        r = $urandom_range(0, 9);
        abs_start = (r == 0) ? rand64() : window + 64'($urandom_range(0, 4096));
        r = $urandom_range(0, 9);
        if (r == 0)
            rsize = rand64();
        else if (r == 1)
            rsize = '0;
        else
            rsize = 64'($urandom_range(0, 512));
        rel = 1'($urandom_range(0, 1));
        send_item(CMD_LOAD, rel, rel ? abs_start - cur_base : abs_start, rsize, rand64());
    endtask

    // lookup aimed at region edges, inside a region, or anywhere
    task automatic lookup_near(logic [63:0] window);
        logic [63:0] target;
        logic [63:0] lo;
        logic [63:0] sz;
        int          e;
        int          r;
        r = $urandom_range(0, 9);
        if (loaded_start.size() == 0 || r == 0)
        begin
            target = ($urandom_range(0, 1) != 0) ? rand64()
                                                 : window + 64'($urandom_range(0, 5000));
        end
        else
        begin
            e = $urandom_range(0, loaded_start.size() - 1);
            lo = loaded_start[e];
            sz = loaded_size[e];
            case ($urandom_range(0, 4))
                0: target = lo;
                1: target = lo + sz;
                2: target = lo - 1;
                3: target = lo + sz + 1;
                default: target = lo + ((sz == '0) ? '0 : rand64() % sz);
            endcase
        end
        send_item(CMD_LOOKUP, 1'($urandom_range(0, 1)), rand64(), rand64(), target);
    endtask

    initial
    begin
        logic [63:0] window;
        int          seq;
        int          n;
        int          wait_cycles;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        calm = 1'b0;
        cur_base = '0;
        sent = 0;
        stall_left = 0;
        seq = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // base near the top so relative starts wrap
        write_base(64'hFFFF_FFFF_FFFF_FF00);

        // empty table miss
        send_item(CMD_LOOKUP, 1'b0, '0, '0, '0);
        send_item(CMD_CLEAR, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
        // zero-size region, plain region, region whose end passes 2^64
        send_item(CMD_LOAD, 1'b0, '0, '0, ALL_ONES);
        send_item(CMD_LOAD, 1'b0, 64'h1000, 64'hFF, '0);
        send_item(CMD_LOAD, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0, ALL_ONES, '0);
        // relative start that wraps, and relative start at the base
        send_item(CMD_LOAD, 1'b1, 64'h200, 64'h10, '0);
        send_item(CMD_LOAD, 1'b1, '0, 64'h7F, '0);
        // catch-all region behind the others
        send_item(CMD_LOAD, 1'b0, '0, ALL_ONES, '0);
        // lookups on edges, first match wins
        send_item(CMD_LOOKUP, 1'b1, ALL_ONES, ALL_ONES, '0);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'h1);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'h1000);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'h10FF);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'h1100);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, ALL_ONES);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'hFFFF_FFFF_FFFF_FFEF);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'h110);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'hFF);
        // unused command leaves the table alone
        send_item(CMD_IGNORED, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, 64'h100);
        // cleared table misses everything
        send_item(CMD_CLEAR, 1'b0, '0, '0, '0);
        send_item(CMD_LOOKUP, 1'b0, '0, '0, ALL_ONES);

        // random runs
        while (sent < ITEM_GOAL)
        begin
            seq++;
            if (seq % 9 == 0)
            begin
                case ((seq / 9) % 4)
                    0: write_base('0);
                    1: write_base(ALL_ONES);
                    2: write_base(64'h8000_0000_0000_0000);
                    default: write_base(rand64());
                endcase
            end
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0: window = '0;
                1: window = ALL_ONES - 64'd3000;
                default: window = rand64();
            endcase
            if ($urandom_range(0, 9) == 0)
            begin
                // noise: any command, any content
                repeat ($urandom_range(3, 8))
                    send_item(CMD_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              rand64(), rand64(), rand64());
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    send_item(CMD_CLEAR, 1'($urandom_range(0, 1)), rand64(), rand64(),
                              rand64());
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
                repeat (n)
                    load_region(window);
                n = $urandom_range(4, 16);
                repeat (n)
                    lookup_near(window);
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // drain outstanding results
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
